@@ rtl/nrfrp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrfrp_pkg: shared types and constants of the receive filter and ring placer
// Holds the stream field layouts, the codes used on the ports and the
// multicast hash function.
// ----------------------------------------------------------------------------
package nrfrp_pkg;

    // Input item kinds carried on s_axis_tuser.
    localparam logic [1:0] KIND_FRAME    = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY = 2'd1;
    localparam logic [1:0] KIND_CURRENT  = 2'd2;

    // Result outcome codes.
    localparam logic [1:0] OUTCOME_STORED   = 2'd0;
    localparam logic [1:0] OUTCOME_STOPPED  = 2'd1;
    localparam logic [1:0] OUTCOME_FULL     = 2'd2;
    localparam logic [1:0] OUTCOME_FILTERED = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_STOPPED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_STOP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STATION    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MCAST      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_MASK   = 3'd6;

    // Receive mode bits.
    localparam int MODE_BCAST_BIT   = 2;
    localparam int MODE_MCAST_BIT   = 3;
    localparam int MODE_PROMISC_BIT = 4;

    // Header status byte values.
    localparam logic [7:0] STATUS_OK    = 8'h01;
    localparam logic [7:0] STATUS_GROUP = 8'h20;

    localparam logic [47:0] BCAST_MAC   = 48'hffff_ffff_ffff;
    localparam logic [31:0] CRC_PRESET  = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY_LO = 32'h04c1_1db6;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] dest_mac;
        logic [10:0] frame_length;
        logic [7:0]  page_value;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  outcome;
        logic [7:0]  status_byte;
        logic [7:0]  header_page;
        logic [7:0]  next_page;
        logic [10:0] stored_length;
        logic        irq_line;
    } result_t;

    // CRC-32, shifted left with no final inversion, over the six address bytes, first byte first, each
    // byte least significant bit first; the hash is the top six bits.
    // The whole loop folds into a small XOR network.
    function automatic logic [5:0] mcast_hash(input logic [47:0] mac);
        logic [31:0] crc;
        logic        fb;
        crc = CRC_PRESET;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 8; j++) begin
                fb  = crc[31] ^ mac[40 - 8 * i + j];
                crc = {crc[30:0], 1'b0};
                if (fb) begin
                    crc = (crc ^ CRC_POLY_LO) | 32'h1;
                end
            end
        end
        return crc[31:26];
    endfunction

endpackage
`default_nettype wire

@@ rtl/nic_rx_filter_ring_placer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nic_rx_filter_ring_placer_unit: receive address filter and ring page placer
// Decides for each received frame whether it enters the paged receive ring,
// and where, in the manner of an 8390-style controller.
// ----------------------------------------------------------------------------
// Usage
// The s_axis channel carries one transaction per item: tuser gives the kind
// (frame arrival, boundary page write or current page write), tdata the
// destination address, the frame length and the page value. Every frame
// arrival yields exactly one transaction on m_axis with the accept flag,
// the drop reason, the header status byte, header and next pages, the stored
// length and the interrupt level. Page writes yield no result.
// The cfg channel writes the configuration registers; it is always ready,
// and is meant to be used only while no item is in flight.
// An accepted item is held in the input register; then the filter, ring
// space check and page arithmetic resolve in one pass into the result
// register. Throughput is one item per cycle while m_axis is not stalled;
// the ring state an item updates is seen by the very next item. When the
// receiver stalls m_axis, the result holds, a further frame waits in the
// input register, and s_axis_tready drops only once both are occupied.
// Page writes pass through even during that wait only if nothing is
// queued ahead of them.
// Reset clears all configuration registers, the write and boundary pages and
// the receive interrupt status, and empties both registers.
// ----------------------------------------------------------------------------
module nic_rx_filter_ring_placer_unit #(
    parameter int MAX_FRAME_BYTES = 1514,
    parameter int MIN_FRAME_BYTES = 60
) (
    input  wire  logic                                 clk,
    input  wire  logic                                 rst_n,
    // Input stream.
    input  wire  logic                                 s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata, from bit 0: dest_mac[47:0], frame_length[58:48],
    // page_value[66:59], zero fill up to bit 71.
    input  wire  logic [nrfrp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser, from bit 0: kind[1:0].
    input  wire  logic [1:0]                           s_axis_tuser,
    // Result stream.
    output logic                                       m_axis_tvalid,
    input  wire  logic                                 m_axis_tready,
    // tdata, from bit 0: status_byte[7:0], header_page[15:8],
    // next_page[23:16], stored_length[34:24], irq_line[35], zero fill to 39.
    output logic [nrfrp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // tuser, from bit 0: accepted[0], outcome[2:1].
    output logic [2:0]                                 m_axis_tuser,
    // Configuration write channel.
    input  wire  logic                                 cfg_valid,
    output logic                                       cfg_ready,
    input  wire  logic [nrfrp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  logic [63:0]                          cfg_data
);

    // Widths of the length and page arithmetic follow the largest frame, but
    // never drop below the width of the incoming length field.
    localparam int LEN_RAW_W = $clog2(MAX_FRAME_BYTES + 8 + 256);
    localparam int LEN_W  = (LEN_RAW_W > 11) ? LEN_RAW_W : 11;
    localparam int ADV_W  = LEN_W - 8;
    localparam int NEXT_W = ((ADV_W > 8) ? ADV_W : 8) + 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(MIN_FRAME_BYTES);
    // Pages that must be free: less than MAX_FRAME_BYTES + 4 bytes is full.
    localparam logic signed [9:0] FULL_PAGES =
        10'((MAX_FRAME_BYTES + 4 + 255) / 256);

    // Configuration registers.
    logic        rx_stopped_reg;
    logic [7:0]  rx_mode_reg;
    logic [7:0]  ring_start_reg;
    logic [7:0]  ring_stop_reg;
    logic [47:0] station_mac_reg;
    logic [63:0] mcast_filter_reg;
    logic [7:0]  int_mask_reg;

    // Ring state. Only bit 0 of the interrupt status is ever set here.
    logic        write_page_valid;
    logic [7:0]  write_page_reg;
    logic [7:0]  write_page_next;
    logic [7:0]  read_boundary_reg;
    logic        rx_int_reg;
    logic        rx_int_next;

    // Input and result registers.
    logic                 in_valid_reg;
    nrfrp_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg;
    nrfrp_pkg::result_t   result_reg;
    nrfrp_pkg::result_t   result_next;

    logic advance;
    logic is_frame;

    // Working signals of the single pass.
    logic signed [9:0] free_pages;
    logic              ring_full;
    logic              addr_pass;
    logic [LEN_W-1:0]  len_clamped;
    logic [LEN_W-1:0]  len_plus;
    logic [ADV_W-1:0]  page_adv;
    logic [NEXT_W-1:0] next_raw;
    logic [NEXT_W-1:0] next_wrapped;
    logic [1:0]        outcome;

    assign write_page_valid = 1'b1;
    assign cfg_ready        = 1'b1;

    assign is_frame = (in_item_reg.kind == nrfrp_pkg::KIND_FRAME);
    // Page writes and the ignored kind never need the result register.
    assign advance = in_valid_reg && (!is_frame || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Free space in pages. With the write page behind the boundary the gap is
    // free; otherwise the free part is the ring size less the used span.
    always_comb
    begin
        if (write_page_reg <= read_boundary_reg)
        begin
            free_pages = $signed({2'b00, read_boundary_reg})
                       - $signed({2'b00, write_page_reg});
        end
        else
        begin
            free_pages = ($signed({2'b00, ring_stop_reg}) - $signed({2'b00, ring_start_reg}))
                       - ($signed({2'b00, write_page_reg})
                          - $signed({2'b00, read_boundary_reg}));
        end
        ring_full = (free_pages < FULL_PAGES);
    end

    // Address filter: promiscuous passes all, broadcast and multicast need
    // their mode bits, and unicast must match the station address.
    always_comb
    begin
        if (rx_mode_reg[nrfrp_pkg::MODE_PROMISC_BIT])
        begin
            addr_pass = 1'b1;
        end
        else if (in_item_reg.dest_mac == nrfrp_pkg::BCAST_MAC)
        begin
            addr_pass = rx_mode_reg[nrfrp_pkg::MODE_BCAST_BIT];
        end
        else if (in_item_reg.dest_mac[40])
        begin
            addr_pass = rx_mode_reg[nrfrp_pkg::MODE_MCAST_BIT]
                     && mcast_filter_reg[nrfrp_pkg::mcast_hash(in_item_reg.dest_mac)];
        end
        else
        begin
            addr_pass = (in_item_reg.dest_mac == station_mac_reg);
        end
    end

    // Length padding and next page computation.
    always_comb
    begin
        len_clamped = LEN_W'(in_item_reg.frame_length);
        if (len_clamped > MAX_LEN)
        begin
            len_clamped = MAX_LEN;
        end
        if (len_clamped < MIN_LEN)
        begin
            len_clamped = MIN_LEN;
        end
        // Four header bytes plus the four added to the stored length, rounded up to pages.
        len_plus     = len_clamped + LEN_W'(8 + 255);
        page_adv     = len_plus[LEN_W-1:8];
        next_raw     = NEXT_W'(write_page_reg) + NEXT_W'(page_adv);
        next_wrapped = next_raw;
        if (next_raw >= NEXT_W'(ring_stop_reg))
        begin
            next_wrapped = next_raw - NEXT_W'(ring_stop_reg) + NEXT_W'(ring_start_reg);
        end
    end

    always_comb
    begin
        if (rx_stopped_reg)
        begin
            outcome = nrfrp_pkg::OUTCOME_STOPPED;
        end
        else if (ring_full)
        begin
            outcome = nrfrp_pkg::OUTCOME_FULL;
        end
        else if (!addr_pass)
        begin
            outcome = nrfrp_pkg::OUTCOME_FILTERED;
        end
        else
        begin
            outcome = nrfrp_pkg::OUTCOME_STORED;
        end
    end

    // Result and state updates for the item in the input register.
    always_comb
    begin
        write_page_next = write_page_reg;
        rx_int_next     = rx_int_reg;
        result_next     = '0;
        result_next.outcome  = outcome;
        result_next.irq_line = rx_int_reg && int_mask_reg[0];
        if (outcome == nrfrp_pkg::OUTCOME_STORED)
        begin
            result_next.accepted      = 1'b1;
            result_next.status_byte   = nrfrp_pkg::STATUS_OK
                | (in_item_reg.dest_mac[40] ? nrfrp_pkg::STATUS_GROUP : 8'h00);
            result_next.header_page   = write_page_reg;
            result_next.next_page     = next_wrapped[7:0];
            result_next.stored_length = 11'(len_clamped + LEN_W'(4));
            result_next.irq_line      = int_mask_reg[0];
            write_page_next           = next_wrapped[7:0];
            rx_int_next               = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_stopped_reg   <= 1'b0;
            rx_mode_reg      <= '0;
            ring_start_reg   <= '0;
            ring_stop_reg    <= '0;
            station_mac_reg  <= '0;
            mcast_filter_reg <= '0;
            int_mask_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nrfrp_pkg::CFG_RX_STOPPED: rx_stopped_reg   <= cfg_data[0];
                nrfrp_pkg::CFG_RX_MODE:    rx_mode_reg      <= cfg_data[7:0];
                nrfrp_pkg::CFG_RING_START: ring_start_reg   <= cfg_data[7:0];
                nrfrp_pkg::CFG_RING_STOP:  ring_stop_reg    <= cfg_data[7:0];
                nrfrp_pkg::CFG_STATION:    station_mac_reg  <= cfg_data[47:0];
                nrfrp_pkg::CFG_MCAST:      mcast_filter_reg <= cfg_data;
                nrfrp_pkg::CFG_INT_MASK:   int_mask_reg     <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_page_reg    <= '0;
            read_boundary_reg <= '0;
            rx_int_reg        <= 1'b0;
        end
        else if (advance && write_page_valid)
        begin
            case (in_item_reg.kind)
                nrfrp_pkg::KIND_BOUNDARY: read_boundary_reg <= in_item_reg.page_value;
                nrfrp_pkg::KIND_CURRENT:  write_page_reg    <= in_item_reg.page_value;
                nrfrp_pkg::KIND_FRAME:
                begin
                    write_page_reg <= write_page_next;
                    rx_int_reg     <= rx_int_next;
                end
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind         <= s_axis_tuser;
            in_item_reg.dest_mac     <= s_axis_tdata[47:0];
            in_item_reg.frame_length <= s_axis_tdata[58:48];
            in_item_reg.page_value   <= s_axis_tdata[66:59];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_frame)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_frame)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000,
                            result_reg.irq_line,
                            result_reg.stored_length,
                            result_reg.next_page,
                            result_reg.header_page,
                            result_reg.status_byte};
    assign m_axis_tuser  = {result_reg.outcome, result_reg.accepted};

endmodule
`default_nettype wire

@@ tb/nic_rx_filter_ring_placer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nic_rx_filter_ring_placer_unit_tb: self-checking bench for the receive filter
// Sends frame arrivals and page writes on the input stream and keeps its own
// copy of the address filter, the ring space check and the page arithmetic.
// Every result transaction is checked field by field against that copy,
// while the source pauses in random bursts and the sink stalls on its own.
// ----------------------------------------------------------------------------
module nic_rx_filter_ring_placer_unit_tb;

    localparam int FRAME_MAX_BYTES = 1514;
    localparam int FRAME_MIN_BYTES = 60;
    // Kind code that the block ignores without a result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Settling time, with margin, for items that leave no result.
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PRINT_LIMIT    = 50;
    localparam logic [47:0] HOME_MAC  = 48'h02_1a_2b_3c_4d_5e;
    localparam logic [47:0] GROUP_MAC = 48'h01_00_5e_00_00_fb;

    // ------------------------------------------------------------------------
    // Mirror of the ring placer. It holds its own copy of the configuration
    // and of the ring pages, works out the result of each accepted frame and
    // keeps those results in arrival order until the block delivers them.
    // ------------------------------------------------------------------------
    class ring_mirror;
        bit          rx_stopped;
        bit [7:0]    rx_mode;
        bit [7:0]    ring_start;
        bit [7:0]    ring_stop;
        bit [47:0]   own_mac;
        bit [63:0]   mcast_mask;
        bit [7:0]    irq_enable;
        bit [7:0]    wr_page;
        bit [7:0]    bnd_page;
        bit [7:0]    irq_status;
        nrfrp_pkg::result_t expected_placements[$];
        int          errors;
        int          checked;

        function void write_reg(input logic [nrfrp_pkg::CFG_IDX_W-1:0] idx,
                                input logic [63:0] value);
            case (idx)
                nrfrp_pkg::CFG_RX_STOPPED: rx_stopped = value[0];
                nrfrp_pkg::CFG_RX_MODE:    rx_mode    = value[7:0];
                nrfrp_pkg::CFG_RING_START: ring_start = value[7:0];
                nrfrp_pkg::CFG_RING_STOP:  ring_stop  = value[7:0];
                nrfrp_pkg::CFG_STATION:    own_mac    = value[47:0];
                nrfrp_pkg::CFG_MCAST:      mcast_mask = value;
                nrfrp_pkg::CFG_INT_MASK:   irq_enable = value[7:0];
                default: ;
            endcase
        endfunction

        // CRC-32 with the preset all ones and no final inversion, run over the
        // address bytes first to last, each byte least significant bit first.
        function bit [5:0] hash_index(input bit [47:0] mac);
            bit [31:0] crc;
            bit [7:0]  octet;
            bit        fb;
            crc = nrfrp_pkg::CRC_PRESET;
            for (int i = 0; i < 6; i++)
            begin
                octet = mac[47 - 8 * i -: 8];
                for (int j = 0; j < 8; j++)
                begin
                    fb    = crc[31] ^ octet[0];
                    crc   = crc << 1;
                    octet = octet >> 1;
                    if (fb)
                        crc = (crc ^ nrfrp_pkg::CRC_POLY_LO) | 32'h1;
                end
            end
            return crc[31:26];
        endfunction

        // Free bytes run from the write page up to the boundary, around the
        // ring when the write page is past the boundary. Equal pages are full.
        function bit ring_is_full();
            int idx, bnd, first, last, room;
            idx   = int'(wr_page);
            bnd   = int'(bnd_page);
            first = int'(ring_start);
            last  = int'(ring_stop);
            if (idx <= bnd)
                room = (bnd - idx) * 256;
            else
                room = (last - first) * 256 - (idx - bnd) * 256;
            return room < FRAME_MAX_BYTES + 4;
        endfunction

        function bit address_passes(input bit [47:0] mac);
            if (rx_mode[nrfrp_pkg::MODE_PROMISC_BIT])
                return 1'b1;
            if (mac == nrfrp_pkg::BCAST_MAC)
                return rx_mode[nrfrp_pkg::MODE_BCAST_BIT];
            if (mac[40])
                return rx_mode[nrfrp_pkg::MODE_MCAST_BIT] && mcast_mask[hash_index(mac)];
            return mac == own_mac;
        endfunction

        function void note_item(input nrfrp_pkg::in_item_t it);
            nrfrp_pkg::result_t r;
            int                 len, total, nxt;
            case (it.kind)
                nrfrp_pkg::KIND_BOUNDARY: bnd_page = it.page_value;
                nrfrp_pkg::KIND_CURRENT:  wr_page  = it.page_value;
                nrfrp_pkg::KIND_FRAME:
                begin
                    r = '0;
                    if (rx_stopped)
                        r.outcome = nrfrp_pkg::OUTCOME_STOPPED;
                    else if (ring_is_full())
                        r.outcome = nrfrp_pkg::OUTCOME_FULL;
                    else if (!address_passes(it.dest_mac))
                        r.outcome = nrfrp_pkg::OUTCOME_FILTERED;
                    else
                        r.outcome = nrfrp_pkg::OUTCOME_STORED;
                    if (r.outcome == nrfrp_pkg::OUTCOME_STORED)
                    begin
                        len = int'(it.frame_length);
                        if (len > FRAME_MAX_BYTES)
                            len = FRAME_MAX_BYTES;
                        if (len < FRAME_MIN_BYTES)
                            len = FRAME_MIN_BYTES;
                        total = len + 4;
                        // Pages needed include the four-byte header.
                        nxt = int'(wr_page) + ((total + 4 + 255) >> 8);
                        if (nxt >= int'(ring_stop))
                            nxt = nxt - int'(ring_stop) + int'(ring_start);
                        r.accepted      = 1'b1;
                        r.status_byte   = nrfrp_pkg::STATUS_OK
                            | (it.dest_mac[40] ? nrfrp_pkg::STATUS_GROUP : 8'h00);
                        r.header_page   = wr_page;
                        r.next_page     = nxt[7:0];
                        r.stored_length = total[10:0];
                        wr_page         = nxt[7:0];
                        irq_status      = irq_status | 8'h01;
                    end
                    r.irq_line = (irq_status & irq_enable & 8'h7f) != 8'h00;
                    expected_placements.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report(input string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t ns: %s", $time, what);
        endtask

        task check_field(input string field, input logic [15:0] got, input logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                 checked, field, got, want));
        endtask

        task check_result(input logic [nrfrp_pkg::OUT_TDATA_W-1:0] tdata,
                          input logic [2:0] tuser);
            nrfrp_pkg::result_t want;
            if (expected_placements.size() == 0)
            begin
                report("result transaction arrived with no frame outstanding");
                return;
            end
            want = expected_placements.pop_front();
            check_field("accepted",      16'(tuser[0]),     16'(want.accepted));
            check_field("outcome",       16'(tuser[2:1]),   16'(want.outcome));
            check_field("status_byte",   16'(tdata[7:0]),   16'(want.status_byte));
            check_field("header_page",   16'(tdata[15:8]),  16'(want.header_page));
            check_field("next_page",     16'(tdata[23:16]), 16'(want.next_page));
            check_field("stored_length", 16'(tdata[34:24]), 16'(want.stored_length));
            check_field("irq_line",      16'(tdata[35]),    16'(want.irq_line));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                              clk;
    logic                              rst_n          = 1'b0;
    logic                              s_axis_tvalid  = 1'b0;
    logic                              s_axis_tready;
    logic [nrfrp_pkg::IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic [1:0]                        s_axis_tuser   = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready  = 1'b0;
    logic [nrfrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]                        m_axis_tuser;
    logic                              cfg_valid      = 1'b0;
    logic                              cfg_ready;
    logic [nrfrp_pkg::CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [63:0]                       cfg_data       = '0;

    ring_mirror book;
    // Bumped by the stimulus to ask the sink for one long hold-off.
    int holdoff_requests = 0;

    nic_rx_filter_ring_placer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Each is entered just after a rising edge and returns just
    // after a rising edge once its transaction was taken. All block inputs are
    // driven with nonblocking assignments so the block sees them settled at
    // the next edge; handshakes are sampled before that edge's updates land.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [nrfrp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        book.write_reg(idx, value);
        // Drop valid until the next edge so back-to-back writes never assign it twice
        // in one time step.
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic stopped, input logic [7:0] mode,
                             input logic [7:0] first_page, input logic [7:0] last_page,
                             input logic [47:0] station, input logic [63:0] mcast,
                             input logic [7:0] mask);
        write_reg(nrfrp_pkg::CFG_RX_STOPPED, {63'd0, stopped});
        write_reg(nrfrp_pkg::CFG_RX_MODE,    {56'd0, mode});
        write_reg(nrfrp_pkg::CFG_RING_START, {56'd0, first_page});
        write_reg(nrfrp_pkg::CFG_RING_STOP,  {56'd0, last_page});
        write_reg(nrfrp_pkg::CFG_STATION,    {16'd0, station});
        write_reg(nrfrp_pkg::CFG_MCAST,      mcast);
        write_reg(nrfrp_pkg::CFG_INT_MASK,   {56'd0, mask});
    endtask

    // Offers one item and leaves valid high; the caller lowers it for a gap.
    task automatic offer_item(input nrfrp_pkg::in_item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, it.page_value, it.frame_length, it.dest_mac};
        s_axis_tuser  <= it.kind;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        book.note_item(it);
    endtask

    task automatic send(input logic [1:0] kind, input logic [47:0] mac,
                        input logic [10:0] len, input logic [7:0] page);
        nrfrp_pkg::in_item_t it;
        it.kind         = kind;
        it.dest_mac     = mac;
        it.frame_length = len;
        it.page_value   = page;
        offer_item(it);
    endtask

    // Stops offering, waits for every outstanding result and then for the
    // pipeline to empty of page writes, which leave no result behind them.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.expected_placements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_mode();
        case ($urandom_range(0, 4))
            0:       return 8'h0c;
            1:       return 8'h04;
            2:       return 8'h08;
            3:       return 8'h10;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Random item source. Most items are frames with plausible addresses; the
    // boundary writes mostly move the boundary just behind the write page so the
    // ring keeps draining and frames go on being stored, with the odd wild
    // page write and ignored kind mixed in as noise.
    // ------------------------------------------------------------------------
    function automatic nrfrp_pkg::in_item_t pick_item();
        nrfrp_pkg::in_item_t it;
        logic [63:0]         raw;
        int                  roll;
        raw             = {$urandom, $urandom};
        roll            = $urandom_range(0, 99);
        it.kind         = nrfrp_pkg::KIND_FRAME;
        it.dest_mac     = raw[47:0];
        it.page_value   = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
            0, 1, 2:    it.frame_length = 11'($urandom_range(0, 80));
            3, 4:       it.frame_length = 11'($urandom_range(1400, FRAME_MAX_BYTES));
            5:          it.frame_length = 11'($urandom_range(FRAME_MAX_BYTES + 1, 2047));
            default:    it.frame_length = 11'($urandom_range(0, FRAME_MAX_BYTES));
        endcase
        if (roll < 70)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:    it.dest_mac = book.own_mac;
                7, 8, 9:                it.dest_mac = nrfrp_pkg::BCAST_MAC;
                10, 11, 12, 13, 14, 15: it.dest_mac[40] = 1'b1;
                default: ;
            endcase
        end
        else if (roll < 85)
        begin
            it.kind = nrfrp_pkg::KIND_BOUNDARY;
            if ($urandom_range(0, 3) != 0)
                it.page_value = (book.wr_page == book.ring_start) ?
                                book.ring_stop - 8'd1 : book.wr_page - 8'd1;
        end
        else if (roll < 95)
        begin
            it.kind = nrfrp_pkg::KIND_CURRENT;
            if ($urandom_range(0, 2) != 0 && book.ring_stop > book.ring_start)
                it.page_value = 8'($urandom_range(book.ring_start, book.ring_stop - 1));
        end
        else if (roll < 97)
            it.kind = KIND_UNUSED;
        return it;
    endfunction

    // Sends a number of counted items in bursts of random length. Ignored
    // items do not count. With no_gaps set the source never pauses.
    task automatic run_phase(input int count, input bit no_gaps);
        nrfrp_pkg::in_item_t it;
        int                  sent, burst;
        sent  = 0;
        burst = 0;
        while (sent < count)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if (!no_gaps && $urandom_range(0, 3) != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
            end
            it = pick_item();
            offer_item(it);
            burst--;
            if (it.kind != KIND_UNUSED)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink. It checks each result transaction and then chooses ready
    // for the next edge from a stall pattern that changes every so often:
    // always ready, coin toss, rare stalls or rare acceptance. A hold-off
    // request keeps ready low for a long stretch counted here.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int tempo, tempo_left, hold_left, holds_served;
        tempo        = 0;
        tempo_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                book.check_result(m_axis_tdata, m_axis_tuser);
            if (holds_served != holdoff_requests)
            begin
                holds_served = holdoff_requests;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (tempo_left == 0)
            begin
                tempo      = $urandom_range(0, 3);
                tempo_left = $urandom_range(20, 200);
            end
            else
                tempo_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (tempo)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1) != 0;
                    2:       m_axis_tready <= $urandom_range(0, 9) != 0;
                    default: m_axis_tready <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    // Guard against a hung block.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, a directed walk through the special cases, then random
    // phases under several register settings, each set up while idle.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [63:0] raw;
        logic [47:0] station;
        int          first, last;
        book = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Straight out of reset both ring pages are zero, so the ring is full.
        send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd64, 8'h00);
        drain();

        // A stopped receiver drops the frame ahead of every other check.
        configure(1'b1, 8'h0c, 8'h40, 8'h80, HOME_MAC, 64'hffff_ffff_ffff_ffff, 8'hff);
        send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd100, 8'h00);
        drain();
        write_reg(nrfrp_pkg::CFG_RX_STOPPED, 64'd0);

        // Open ring from page 0x40 up to the boundary at 0x7f.
        send(nrfrp_pkg::KIND_CURRENT, 48'h0, 11'd0, 8'h40);
        send(nrfrp_pkg::KIND_BOUNDARY, 48'h0, 11'd0, 8'h7f);
        // Empty and short frames are padded; oversized ones saturate.
        send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd0, 8'h00);
        send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd59, 8'hff);
        send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd1514, 8'h00);
        send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd2047, 8'h00);
        // Broadcast and a hashed group address, then a stranger's address.
        send(nrfrp_pkg::KIND_FRAME, nrfrp_pkg::BCAST_MAC, 11'd100, 8'h00);
        send(nrfrp_pkg::KIND_FRAME, GROUP_MAC, 11'd200, 8'h00);
        send(nrfrp_pkg::KIND_FRAME, 48'h0, 11'd60, 8'h00);
        // The unused kind must vanish without a result.
        send(KIND_UNUSED, 48'hffff_ffff_ffff, 11'h7ff, 8'hff);

        // Write page just below the stop page: the next page wraps to the
        // start, then the ring fills until the boundary is reached.
        send(nrfrp_pkg::KIND_BOUNDARY, 48'h0, 11'd0, 8'h50);
        send(nrfrp_pkg::KIND_CURRENT, 48'h0, 11'd0, 8'h7e);
        repeat (4) send(nrfrp_pkg::KIND_FRAME, HOME_MAC, 11'd1514, 8'h00);
        drain();

        // With no mode bits only the own address passes.
        write_reg(nrfrp_pkg::CFG_RX_MODE, 64'd0);
        send(nrfrp_pkg::KIND_BOUNDARY, 48'h0, 11'd0, 8'h7f);
        send(nrfrp_pkg::KIND_FRAME, nrfrp_pkg::BCAST_MAC, 11'd100, 8'h00);
        send(nrfrp_pkg::KIND_FRAME, GROUP_MAC, 11'd100, 8'h00);
        drain();

        // Promiscuous, with the stop page below the start page: a frame below
        // the boundary still lands, one past it finds the ring full.
        configure(1'b0, 8'h10, 8'h80, 8'h40, HOME_MAC, 64'd0, 8'h80);
        send(nrfrp_pkg::KIND_FRAME, 48'h1234_5678_9abc, 11'd300, 8'h00);
        send(nrfrp_pkg::KIND_BOUNDARY, 48'h0, 11'd0, 8'h20);
        send(nrfrp_pkg::KIND_FRAME, 48'h1234_5678_9abc, 11'd300, 8'h00);

        // Random phases. The first two use the extreme ring settings, the
        // third runs with the receiver stopped and the fourth carries the
        // long sink hold-off with the source never pausing.
        for (int phase = 0; phase < 8; phase++)
        begin
            raw         = {$urandom, $urandom};
            station     = raw[47:0];
            station[40] = 1'b0;
            first       = $urandom_range(0, 200);
            last        = first + $urandom_range(7, 55);
            drain();
            case (phase)
                0: configure(1'b0, 8'h0c, 8'h00, 8'hff, 48'h0, raw, 8'hff);
                1: configure(1'b0, 8'hff, 8'hff, 8'h00, nrfrp_pkg::BCAST_MAC, 64'd0, 8'h00);
                2: configure(1'b1, pick_mode(), first[7:0], last[7:0], station, raw, 8'h01);
                default:
                    configure(1'b0, pick_mode(), first[7:0], last[7:0], station,
                              ($urandom_range(0, 3) == 0) ? 64'hffff_ffff_ffff_ffff :
                                                             {$urandom, $urandom},
                              8'($urandom_range(0, 255)));
            endcase
            if (phase == 3)
                holdoff_requests++;
            run_phase((phase == 2) ? 20 : 85, phase == 3);
        end

        drain();
        if (book.expected_placements.size() != 0)
            book.report($sformatf("%0d expected results never arrived",
                                  book.expected_placements.size()));
        if (book.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
